[src/stp_pkg.sv]
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the source text prefilter
// Defines the operations passed from the line-join front end to the comment
// and whitespace back end, the result record and the register codes.
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int FRONT_OPS   = 5;
   localparam int FRONT_CNT_W = $clog2(FRONT_OPS + 1);
   localparam int BACK_RES    = 4;
   localparam int BACK_AW     = $clog2(BACK_RES);
   localparam int BACK_CNT_W  = $clog2(BACK_RES + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] MAX_JOINS_RESET  = 4'd3;
   localparam logic [7:0] END_MARKER_RESET = 8'd35;
   localparam logic [4:0] JOIN_SAT         = 5'd31;

   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   localparam logic [1:0] KIND_CHAR         = 2'd0;
   localparam logic [1:0] KIND_JOIN_ERR     = 2'd1;
   localparam logic [1:0] KIND_OPEN_COMMENT = 2'd2;

   localparam logic CSR_MAX_JOINS  = 1'b0;
   localparam logic CSR_END_MARKER = 1'b1;

   typedef enum logic [1:0] {
      OP_CHAR,
      OP_JOIN_ERR,
      OP_EOF
   } stp_opcode_type;

   typedef struct packed {
      stp_opcode_type code;
      logic [7:0]     data;
   } stp_op_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } stp_rsp_type;

endpackage

[src/stp_front.sv]
// ----------------------------------------------------------------------------
// stp_front: line-join front end
// Accepts raw bytes, joins continued lines, counts joins and turns each byte
// into a short list of operations that is handed on one per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module stp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic [3:0]          max_joins,
   output logic                q_push,
   output stp_pkg::stp_op_type q_data,
   input  logic                q_full
);
   import stp_pkg::*;

   logic                   held_bs_ff, held_bs_in;
   logic                   held_cr_ff, held_cr_in;
   logic                   line_open_ff, line_open_in;
   logic [4:0]             join_ff, join_in;
   logic                   failed_ff, failed_in;
   stp_op_type             ops_ff [FRONT_OPS];
   stp_op_type             ops_in [FRONT_OPS];
   logic [FRONT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FRONT_CNT_W-1:0] n;
   logic                   accept;
   logic                   fail_now;

   assign q_push    = (cnt_ff != '0) && !q_full;
   assign q_data    = ops_ff[0];
   assign req_stall = !((cnt_ff == '0) || ((cnt_ff == FRONT_CNT_W'(1)) && q_push));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_bs_in   = held_bs_ff;
      held_cr_in   = held_cr_ff;
      line_open_in = line_open_ff;
      join_in      = join_ff;
      failed_in    = failed_ff;
      cnt_in       = cnt_ff;
      ops_in       = ops_ff;
      n            = '0;
      fail_now     = 1'b0;
      if (q_push) begin
         for (int i = 0; i < FRONT_OPS - 1; i++) begin
            ops_in[i] = ops_ff[i + 1];
         end
         cnt_in = cnt_ff - FRONT_CNT_W'(1);
      end
      if (accept) begin
         if (!failed_ff) begin
            if (req_in_byte == CH_LF) begin
               if (held_bs_in) begin
                  if (join_in != JOIN_SAT) begin
                     join_in = join_in + 5'd1;
                  end
                  if (join_in > {1'b0, max_joins}) begin
                     ops_in[n] = '{OP_JOIN_ERR, 8'd0};
                     n = n + FRONT_CNT_W'(1);
                     fail_now = 1'b1;
                  end
               end else begin
                  ops_in[n] = '{OP_CHAR, CH_LF};
                  n = n + FRONT_CNT_W'(1);
                  join_in = '0;
               end
               held_bs_in   = 1'b0;
               held_cr_in   = 1'b0;
               line_open_in = 1'b0;
            end else begin
               line_open_in = 1'b1;
               if ((req_in_byte != CH_CR) || held_cr_in) begin
                  if (held_bs_in) begin
                     ops_in[n] = '{OP_CHAR, CH_BSL};
                     n = n + FRONT_CNT_W'(1);
                  end
                  if (held_cr_in) begin
                     ops_in[n] = '{OP_CHAR, CH_CR};
                     n = n + FRONT_CNT_W'(1);
                  end
                  held_bs_in = 1'b0;
                  held_cr_in = 1'b0;
               end
               if (req_in_byte == CH_CR) begin
                  held_cr_in = 1'b1;
               end else if (req_in_byte == CH_BSL) begin
                  held_bs_in = 1'b1;
               end else begin
                  ops_in[n] = '{OP_CHAR, req_in_byte};
                  n = n + FRONT_CNT_W'(1);
               end
            end
            if (req_in_last && !fail_now) begin
               if (line_open_in) begin
                  if (held_bs_in) begin
                     if (join_in != JOIN_SAT) begin
                        join_in = join_in + 5'd1;
                     end
                     if (join_in > {1'b0, max_joins}) begin
                        ops_in[n] = '{OP_JOIN_ERR, 8'd0};
                        n = n + FRONT_CNT_W'(1);
                        fail_now = 1'b1;
                     end
                  end else begin
                     ops_in[n] = '{OP_CHAR, CH_LF};
                     n = n + FRONT_CNT_W'(1);
                  end
               end
               if (!fail_now) begin
                  ops_in[n] = '{OP_EOF, 8'd0};
                  n = n + FRONT_CNT_W'(1);
               end
            end
         end
         cnt_in = n;
         if (req_in_last) begin
            held_bs_in   = 1'b0;
            held_cr_in   = 1'b0;
            line_open_in = 1'b0;
            join_in      = '0;
            failed_in    = 1'b0;
         end else if (fail_now) begin
            failed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bs_ff   <= 1'b0;
         held_cr_ff   <= 1'b0;
         line_open_ff <= 1'b0;
         join_ff      <= '0;
         failed_ff    <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         held_bs_ff   <= held_bs_in;
         held_cr_ff   <= held_cr_in;
         line_open_ff <= line_open_in;
         join_ff      <= join_in;
         failed_ff    <= failed_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ops_ff <= ops_in;
   end

   // A request taken after a failure yields no operations.
   assert property (@(posedge clock) disable iff (reset)
      (accept && failed_ff) |=> (cnt_ff == '0))
      else $error("operations produced for a request after a failure");

endmodule

[src/stp_queue.sv]
// ----------------------------------------------------------------------------
// stp_queue: operation queue
// Short first-in first-out buffer that decouples the front end from the back
// end so that either side can stall on its own.
// ----------------------------------------------------------------------------
module stp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stp_pkg::stp_op_type push_data,
   output logic                full,
   input  logic                pop,
   output stp_pkg::stp_op_type pop_data,
   output logic                empty
);
   import stp_pkg::*;

   stp_op_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

[src/stp_back.sv]
// ----------------------------------------------------------------------------
// stp_back: comment and whitespace back end
// Replaces comments by one space, collapses whitespace, holds back a trailing
// end marker and closes each file with the marker or an error result.
// ----------------------------------------------------------------------------
module stp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          end_marker,
   input  logic                q_empty,
   input  stp_pkg::stp_op_type q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_kind,
   output logic                rsp_out_last
);
   import stp_pkg::*;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
   endfunction

   logic                  in_comment_ff, in_comment_in;
   logic                  held_ps_ff, held_ps_in;
   logic                  space_ff, space_in;
   logic                  any_ff, any_in;
   logic                  marker_ff, marker_in;
   stp_rsp_type           res_ff [BACK_RES];
   stp_rsp_type           res_in [BACK_RES];
   logic [BACK_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BACK_CNT_W-1:0] n;
   logic                  s_val [2];
   logic [7:0]            s_chr [2];
   logic                  rsp_take;

   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_out_byte = res_ff[0].data;
   assign rsp_kind     = res_ff[0].kind;
   assign rsp_out_last = res_ff[0].last;
   assign rsp_take     = rsp_valid && !rsp_stall;
   assign q_pop        = !q_empty
                         && ((cnt_ff == '0) || ((cnt_ff == BACK_CNT_W'(1)) && rsp_take));

   always_comb begin
      in_comment_in = in_comment_ff;
      held_ps_in    = held_ps_ff;
      space_in      = space_ff;
      any_in        = any_ff;
      marker_in     = marker_ff;
      res_in        = res_ff;
      cnt_in        = cnt_ff;
      n             = '0;
      for (int k = 0; k < 2; k++) begin
         s_val[k] = 1'b0;
         s_chr[k] = CH_SPACE;
      end
      if (rsp_take) begin
         for (int i = 0; i < BACK_RES - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         cnt_in = cnt_ff - BACK_CNT_W'(1);
      end
      if (q_pop) begin
         case (q_data.code)
            OP_CHAR: begin
               if (in_comment_ff) begin
                  if (held_ps_ff && (q_data.data == CH_SLASH)) begin
                     held_ps_in    = 1'b0;
                     in_comment_in = 1'b0;
                  end else begin
                     held_ps_in = (q_data.data == CH_STAR);
                  end
               end else if (held_ps_ff && (q_data.data == CH_STAR)) begin
                  held_ps_in    = 1'b0;
                  in_comment_in = 1'b1;
                  s_val[0]      = 1'b1;
                  s_chr[0]      = CH_SPACE;
               end else begin
                  s_val[0]   = held_ps_ff;
                  s_chr[0]   = CH_SLASH;
                  held_ps_in = (q_data.data == CH_SLASH);
                  s_val[1]   = (q_data.data != CH_SLASH);
                  s_chr[1]   = q_data.data;
               end
            end
            OP_EOF: begin
               s_val[0] = held_ps_ff && !in_comment_ff;
               s_chr[0] = CH_SLASH;
            end
            default: begin
            end
         endcase
         for (int k = 0; k < 2; k++) begin
            if (s_val[k]) begin
               if (is_ws(s_chr[k])) begin
                  if (any_in) begin
                     space_in = 1'b1;
                  end
               end else begin
                  if (marker_in) begin
                     res_in[n[BACK_AW-1:0]] = '{end_marker, KIND_CHAR, 1'b0};
                     n = n + BACK_CNT_W'(1);
                     marker_in = 1'b0;
                  end
                  if (space_in) begin
                     res_in[n[BACK_AW-1:0]] = '{CH_SPACE, KIND_CHAR, 1'b0};
                     n = n + BACK_CNT_W'(1);
                     space_in = 1'b0;
                  end
                  if (s_chr[k] == end_marker) begin
                     marker_in = 1'b1;
                  end else begin
                     res_in[n[BACK_AW-1:0]] = '{s_chr[k], KIND_CHAR, 1'b0};
                     n = n + BACK_CNT_W'(1);
                  end
                  any_in = 1'b1;
               end
            end
         end
         case (q_data.code)
            OP_EOF: begin
               if (in_comment_ff) begin
                  res_in[n[BACK_AW-1:0]] = '{8'd0, KIND_OPEN_COMMENT, 1'b1};
               end else begin
                  res_in[n[BACK_AW-1:0]] = '{end_marker, KIND_CHAR, 1'b1};
               end
               n = n + BACK_CNT_W'(1);
            end
            OP_JOIN_ERR: begin
               res_in[n[BACK_AW-1:0]] = '{8'd0, KIND_JOIN_ERR, 1'b1};
               n = n + BACK_CNT_W'(1);
            end
            default: begin
            end
         endcase
         if (q_data.code != OP_CHAR) begin
            in_comment_in = 1'b0;
            held_ps_in    = 1'b0;
            space_in      = 1'b0;
            any_in        = 1'b0;
            marker_in     = 1'b0;
         end
         cnt_in = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         held_ps_ff    <= 1'b0;
         space_ff      <= 1'b0;
         any_ff        <= 1'b0;
         marker_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         in_comment_ff <= in_comment_in;
         held_ps_ff    <= held_ps_in;
         space_ff      <= space_in;
         any_ff        <= any_in;
         marker_ff     <= marker_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // Every error result closes its file.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_CHAR)) |-> rsp_out_last)
      else $error("error result without end of file");

   // Closing an operation clears all per-file state.
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && (q_data.code != OP_CHAR)) |=> (!in_comment_ff && !marker_ff && !any_ff))
      else $error("per-file state survives end of file");

endmodule

[src/source_text_prefilter_core.sv]
// ----------------------------------------------------------------------------
// source_text_prefilter_core: streaming source text cleaner
// Joins continued lines, replaces comments by one space, collapses whitespace
// and closes each file with an end marker or an error result.
//
//   Port group | Direction | Contents
//   req_       | in        | in_byte, in_last; valid/stall
//   rsp_       | out       | out_byte, kind, out_last; valid/stall
//   csr_       | in        | wr_en, index, wr_data (max_joins, end_marker)
//
// The front end takes a request and hands on one operation per cycle while
// the queue is not full; a request yields up to five operations. The back
// end turns each operation into up to four results and delivers one result
// per cycle while rsp_stall is low. A four-entry queue parts the front and
// back ends. Reset is synchronous and restores the registers to 3 and 35.
// ----------------------------------------------------------------------------
module source_text_prefilter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic       rsp_out_last,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data
);
   import stp_pkg::*;

   logic [3:0] max_joins_ff;
   logic [7:0] end_marker_ff;
   logic       q_push;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   stp_op_type q_in_data;
   stp_op_type q_out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_joins_ff  <= MAX_JOINS_RESET;
         end_marker_ff <= END_MARKER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_JOINS:  max_joins_ff  <= csr_wr_data[3:0];
            CSR_END_MARKER: end_marker_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   stp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .max_joins   (max_joins_ff),
      .q_push      (q_push),
      .q_data      (q_in_data),
      .q_full      (q_full)
   );

   stp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   stp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .end_marker   (end_marker_ff),
      .q_empty      (q_empty),
      .q_data       (q_out_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_out_last (rsp_out_last)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for source_text_prefilter_core
// Feeds small source files one byte per request and predicts the cleaned
// text: joined lines, comments turned into one space, collapsed whitespace
// and the closing end marker or error result. Each delivered result is
// compared with the oldest predicted one. Both sides idle in random bursts,
// and the line-join limit and end marker are changed between phases.
// ----------------------------------------------------------------------------
module tb;
   import stp_pkg::*;

   localparam int WATCHDOG_LIMIT      = 2000;
   localparam int SETTLE_CYCLES       = 32;
   localparam int RESULTS_PER_REQUEST = 8;

   typedef struct {
      logic [7:0] ch;
      logic       is_last;
   } src_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic       rsp_out_last;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_MAX_JOINS;
   logic [7:0] csr_wr_data = 8'h00;

   src_char_type raw_text_q[$];
   stp_rsp_type  cleaned_text_q[$];

   int mismatches = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int gap_pct = 0;
   int stall_pct = 0;

   // Model of the cleaner state and its register copies.
   logic [3:0] max_joins_cfg = MAX_JOINS_RESET;
   logic [7:0] marker_cfg = END_MARKER_RESET;
   bit         bs_held, cr_held, line_open, in_cmt, pair_held;
   bit         space_owed, text_seen, marker_held, file_failed;
   logic [4:0] joins;
   int         step_results;

   source_text_prefilter_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void emit(logic [7:0] ch, logic [1:0] kind, logic is_last);
      stp_rsp_type r;
      if (step_results >= RESULTS_PER_REQUEST) return;
      r.data = ch;
      r.kind = kind;
      r.last = is_last;
      cleaned_text_q.push_back(r);
      step_results++;
   endfunction

   function automatic void raise_error(logic [1:0] kind);
      emit(8'h00, kind, 1'b1);
      file_failed = 1'b1;
   endfunction

   function automatic void clear_file();
      bs_held = 0; cr_held = 0; line_open = 0; joins = '0; in_cmt = 0;
      pair_held = 0; space_owed = 0; text_seen = 0; marker_held = 0;
      file_failed = 0;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
   endfunction

   function automatic void collapse(logic [7:0] c);
      if (is_blank(c)) begin
         if (text_seen) space_owed = 1'b1;
         return;
      end
      if (marker_held) begin
         emit(marker_cfg, KIND_CHAR, 1'b0);
         marker_held = 1'b0;
      end
      if (space_owed) begin
         emit(CH_SPACE, KIND_CHAR, 1'b0);
         space_owed = 1'b0;
      end
      if (c == marker_cfg) marker_held = 1'b1;
      else emit(c, KIND_CHAR, 1'b0);
      text_seen = 1'b1;
   endfunction

   function automatic void strip_comment(logic [7:0] c);
      if (file_failed) return;
      if (in_cmt) begin
         if (pair_held) begin
            pair_held = 1'b0;
            if (c == CH_SLASH) begin
               in_cmt = 1'b0;
               return;
            end
         end
         if (c == CH_STAR) pair_held = 1'b1;
         return;
      end
      if (pair_held) begin
         pair_held = 1'b0;
         if (c == CH_STAR) begin
            in_cmt = 1'b1;
            collapse(CH_SPACE);
            return;
         end
         collapse(CH_SLASH);
      end
      if (c == CH_SLASH) pair_held = 1'b1;
      else collapse(c);
   endfunction

   function automatic void release_held();
      if (bs_held) strip_comment(CH_BSL);
      if (cr_held) strip_comment(CH_CR);
      bs_held = 1'b0;
      cr_held = 1'b0;
   endfunction

   function automatic void end_line();
      if (bs_held) begin
         if (joins < JOIN_SAT) joins++;
         if (joins > {1'b0, max_joins_cfg}) raise_error(KIND_JOIN_ERR);
      end else begin
         strip_comment(CH_LF);
         joins = '0;
      end
      bs_held = 1'b0;
      cr_held = 1'b0;
      line_open = 1'b0;
   endfunction

   function automatic void join_lines(logic [7:0] c);
      if (c == CH_LF) begin
         end_line();
         return;
      end
      line_open = 1'b1;
      if (c == CH_CR) begin
         if (cr_held) release_held();
         cr_held = 1'b1;
         return;
      end
      release_held();
      if (c == CH_BSL) bs_held = 1'b1;
      else strip_comment(c);
   endfunction

   function automatic void clean_request(logic [7:0] c, logic is_last);
      step_results = 0;
      if (file_failed) begin
         if (is_last) clear_file();
         return;
      end
      join_lines(c);
      if (is_last && !file_failed) begin
         if (line_open) end_line();
         if (!file_failed) begin
            if (in_cmt) begin
               raise_error(KIND_OPEN_COMMENT);
            end else begin
               if (pair_held) begin
                  pair_held = 1'b0;
                  collapse(CH_SLASH);
               end
               emit(marker_cfg, KIND_CHAR, 1'b1);
            end
         end
      end
      if (is_last) clear_file();
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   function automatic void push_char(logic [7:0] ch, bit is_last);
      src_char_type e;
      e.ch = ch;
      e.is_last = is_last;
      raw_text_q.push_back(e);
   endfunction

   function automatic void push_text(string s, bit close_file);
      for (int i = 0; i < s.len(); i++) push_char(8'(s[i]), close_file && i == s.len() - 1);
   endfunction

   function automatic void queue_random_file();
      logic [7:0] txt[$];
      int         n_tok;
      int         run;
      n_tok = int'($urandom_range(1, 10));
      if ($urandom_range(0, 9) == 0) begin
         repeat (n_tok) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (n_tok) begin
            case ($urandom_range(0, 15))
               0, 1, 2, 3: txt.push_back(8'($urandom_range(8'h21, 8'h7E)));
               4: txt.push_back(CH_SPACE);
               5: txt.push_back(8'($urandom_range(CH_HT, CH_CR)));
               6: txt.push_back(CH_LF);
               7: begin
                  run = ($urandom_range(0, 7) == 0) ? int'($urandom_range(12, 17))
                                                    : int'($urandom_range(1, 3));
                  repeat (run) begin
                     txt.push_back(8'($urandom_range(8'h61, 8'h7A)));
                     txt.push_back(CH_BSL);
                     if ($urandom_range(0, 2) == 0) txt.push_back(CH_CR);
                     txt.push_back(CH_LF);
                  end
               end
               8: begin
                  txt.push_back(CH_CR);
                  txt.push_back(CH_LF);
               end
               9: begin
                  txt.push_back(CH_SLASH);
                  txt.push_back(CH_STAR);
               end
               10: begin
                  txt.push_back(CH_STAR);
                  txt.push_back(CH_SLASH);
               end
               11: txt.push_back(CH_SLASH);
               12: txt.push_back(CH_STAR);
               13: txt.push_back(marker_cfg);
               14: txt.push_back(CH_BSL);
               default: txt.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      foreach (txt[i]) push_char(txt[i], i == txt.size() - 1);
   endfunction

   task automatic queue_random_files(int target);
      int n0;
      n0 = raw_text_q.size();
      while (raw_text_q.size() - n0 < target) queue_random_file();
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (raw_text_q.size() != 0 || req_valid || cleaned_text_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(logic [3:0] joins_max, logic [7:0] marker);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAX_JOINS;
      csr_wr_data <= {4'd0, joins_max};
      @(posedge clock);
      csr_index <= CSR_END_MARKER;
      csr_wr_data <= marker;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_joins_cfg = joins_max;
      marker_cfg = marker;
      @(negedge clock);
   endtask

   initial begin
      clear_file();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: joins, CR handling, comments, held marker and slash.
      gap_pct = 10;
      stall_pct = 10;
      push_text("\t#a\\\n\\\015\nb /*c*/ #", 1'b1);
      push_text("/", 1'b1);
      push_text("x\015\015\n/*", 1'b1);
      queue_random_files(28);
      wait_drained();

      // No joins allowed and a NUL marker.
      program_regs(4'd0, 8'h00);
      gap_pct = 3;
      stall_pct = 25;
      push_text("q\\\nzz", 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'h61, 1'b0);
      push_char(8'h00, 1'b1);
      queue_random_files(22);
      wait_drained();

      // Widest join limit and an all-ones marker.
      program_regs(4'd15, 8'hFF);
      gap_pct = 25;
      stall_pct = 3;
      push_char(8'hFF, 1'b1);
      queue_random_files(22);
      wait_drained();

      // A whitespace marker is appended to every file that closes without an error.
      program_regs(4'd1, CH_SPACE);
      gap_pct = 8;
      stall_pct = 8;
      push_text(" a \n", 1'b1);
      queue_random_files(22);
      wait_drained();

      program_regs(MAX_JOINS_RESET, END_MARKER_RESET);
      gap_pct = 0;
      stall_pct = 0;
      queue_random_files(22);
      wait_drained();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   always @(posedge clock) begin : request_driver
      src_char_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) clean_request(req_in_byte, req_in_last);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_valid && raw_text_q.size() != 0 && gap_pct > 0 &&
                         $urandom_range(0, 99) < gap_pct) begin
               send_gap = int'($urandom_range(1, 18)) - 1;
               req_valid <= 1'b0;
            end else if (raw_text_q.size() != 0) begin
               nxt = raw_text_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= nxt.ch;
               req_in_last <= nxt.is_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : cleaned_text_monitor
      stp_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cleaned_text_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result %02h kind %0d last %0b",
                                         rsp_out_byte, rsp_kind, rsp_out_last));
            end else begin
               want = cleaned_text_q.pop_front();
               if (rsp_out_byte !== want.data || rsp_kind !== want.kind ||
                   rsp_out_last !== want.last)
                  report_mismatch($sformatf(
                     "got %02h kind %0d last %0b, want %02h kind %0d last %0b",
                     rsp_out_byte, rsp_kind, rsp_out_last,
                     want.data, want.kind, want.last));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!rsp_stall && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            recv_gap = int'($urandom_range(1, 18)) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule

[filelist.f]
src/stp_pkg.sv
src/stp_front.sv
src/stp_queue.sv
src/stp_back.sv
src/source_text_prefilter_core.sv
tb/tb.sv
